>>> rtl/core/ece_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the enclosing circle extend core.
// No dependencies; used by ece_mul, ece_iter and enclosing_circle_extend_core.
package ece_pkg;

    localparam int CoordW = 32;           // signed Q16.16 coordinate
    localparam int RadW   = 31;           // unsigned Q15.16 radius
    localparam int MagW   = 33;           // magnitude of a 33 bit difference
    localparam int ProdW  = 2 * MagW;     // full product / squared distance
    localparam int RemW   = 37;           // partial remainder of the restoring unit
    localparam int CntW   = 6;

    localparam logic [CntW-1:0] SqrtSteps = 6'd33;
    localparam logic [CntW-1:0] DivSteps  = 6'd32;

    // Configuration register indexes
    localparam logic [1:0] CfgCenterX = 2'd0;
    localparam logic [1:0] CfgCenterY = 2'd1;
    localparam logic [1:0] CfgRadius  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MXX,
        ST_MYY,
        ST_MRR,
        ST_CMP,
        ST_SQRT,
        ST_MHX,
        ST_DXS,
        ST_DXW,
        ST_DYS,
        ST_DYW,
        ST_UPD,
        ST_OUT
    } t_state;

    // Request to the shared square root / divide unit
    typedef struct packed {
        logic             start;
        logic             sqrt_mode;
        logic [ProdW-1:0] operand;
        logic [MagW-1:0]  divisor;
    } t_iter_req;

    typedef struct packed {
        logic            done;
        logic [MagW-1:0] result;
    } t_iter_rsp;

endpackage

>>> rtl/core/ece_mul.sv
`timescale 1ns / 1ps
// Registered 33 x 33 bit unsigned multiplier, product held while not enabled.
// Depends on ece_pkg for widths.
module ece_mul (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [ece_pkg::MagW-1:0]  i_a,
    input  logic [ece_pkg::MagW-1:0]  i_b,
    output logic [ece_pkg::ProdW-1:0] o_prod
);

    logic [ece_pkg::ProdW-1:0] r_prod;
    logic [ece_pkg::ProdW-1:0] n_prod;

    assign n_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/core/ece_iter.sv
`timescale 1ns / 1ps
// Shared restoring unit: bit-pair integer square root or long division,
// one result bit per cycle through a single compare-and-subtract. Depends on ece_pkg.
module ece_iter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ece_pkg::t_iter_req i_req,
    output ece_pkg::t_iter_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [ece_pkg::CntW-1:0]    r_cnt;
    logic                        r_sqrt;
    logic [ece_pkg::RemW-1:0]    r_rem;
    logic [ece_pkg::ProdW-1:0]   r_src;
    logic [ece_pkg::MagW-1:0]    r_q;
    logic [ece_pkg::MagW-1:0]    r_div;

    logic [ece_pkg::RemW-1:0]    sh_a;
    logic [ece_pkg::RemW-1:0]    sh_b;
    logic [ece_pkg::RemW-1:0]    diff;
    logic                        ge;
    logic [ece_pkg::RemW-1:0]    n_rem;
    logic [ece_pkg::ProdW-1:0]   n_src;
    logic [ece_pkg::MagW-1:0]    n_q;

    // Square root: shift in two radicand bits, trial is 4*root + 1.
    // Divide: shift in one dividend bit, trial is the divisor.
    always_comb begin
        if (r_sqrt) begin
            sh_a  = {r_rem[ece_pkg::RemW-3:0], r_src[ece_pkg::ProdW-1 -: 2]};
            sh_b  = {2'b00, r_q, 2'b01};
            n_src = {r_src[ece_pkg::ProdW-3:0], 2'b00};
        end else begin
            sh_a  = {r_rem[ece_pkg::RemW-2:0], r_src[ece_pkg::ProdW-1]};
            sh_b  = {4'b0000, r_div};
            n_src = {r_src[ece_pkg::ProdW-2:0], 1'b0};
        end
        diff  = sh_a - sh_b;
        ge    = (sh_a >= sh_b);
        n_rem = ge ? diff : sh_a;
        n_q   = {r_q[ece_pkg::MagW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.sqrt_mode ? ece_pkg::SqrtSteps : ece_pkg::DivSteps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.sqrt_mode;
            r_q    <= '0;
            r_div  <= i_req.divisor;
            if (i_req.sqrt_mode) begin
                r_rem <= '0;
                r_src <= i_req.operand;
            end else begin
                // Quotient fits 32 bits, so the top 34 dividend bits start below the divisor
                r_rem <= {3'b000, i_req.operand[ece_pkg::ProdW-1:32]};
                r_src <= {i_req.operand[31:0], 34'd0};
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_src <= n_src;
            r_q   <= n_q;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_q;

endmodule

>>> rtl/core/enclosing_circle_extend_core.sv
`timescale 1ns / 1ps
// Top level of the running bounding circle core.
// Depends on ece_pkg, ece_mul and ece_iter.
//
// The core holds a circle (center x/y signed Q16.16, radius unsigned Q15.16) and takes
// one point per input transfer. A point strictly inside leaves the circle as is; any
// other point moves the center toward it by h = floor((d - r) / 2) along the unit
// direction and grows the radius by h, with centers saturating to 32 bits and the radius
// to 31 bits. The restart flag in tuser first reloads the circle from the three
// configuration registers. Each result transfer carries the circle after the point and
// a grew flag. One point is processed at a time. The shared restoring unit forms the
// square root of the squared distance and the two divisions by the distance; a single
// registered 33 x 33 multiplier forms the three squares and the two numerators. The user
// must write configuration only while no point is in flight; the core itself does not
// enforce this.
module enclosing_circle_extend_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // point stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] point_x, [63:32] point_y
    input  logic        s_axis_tuser,   // [0] restart
    // circle stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [31:0] out_center_x, [63:32] out_center_y,
                                        // [94:64] out_radius, [95] zero
    output logic        m_axis_tuser    // [0] grew
);

    ece_pkg::t_state r_state;
    ece_pkg::t_state n_state;

    // configuration registers
    logic [ece_pkg::CoordW-1:0] r_cfg_cx;
    logic [ece_pkg::CoordW-1:0] r_cfg_cy;
    logic [ece_pkg::RadW-1:0]   r_cfg_r;

    // circle state, also the result payload
    logic [ece_pkg::CoordW-1:0] r_cx;
    logic [ece_pkg::CoordW-1:0] r_cy;
    logic [ece_pkg::RadW-1:0]   r_r;
    logic                       r_grew;

    // per point working registers
    logic [ece_pkg::CoordW-1:0] r_px;
    logic [ece_pkg::CoordW-1:0] r_py;
    logic [ece_pkg::MagW-1:0]   r_ax;
    logic [ece_pkg::MagW-1:0]   r_ay;
    logic                       r_negx;
    logic                       r_negy;
    logic [ece_pkg::ProdW-1:0]  r_s;
    logic [ece_pkg::MagW-1:0]   r_d;
    logic [ece_pkg::MagW-1:0]   r_h;
    logic [31:0]                r_qx;
    logic [31:0]                r_qy;

    logic                       mul_en;
    logic [ece_pkg::MagW-1:0]   mul_a;
    logic [ece_pkg::MagW-1:0]   mul_b;
    logic [ece_pkg::ProdW-1:0]  mul_prod;
    ece_pkg::t_iter_req         iter_req;
    ece_pkg::t_iter_rsp         iter_rsp;

    logic                       in_xfer;
    logic [ece_pkg::MagW-1:0]   dx;
    logic [ece_pkg::MagW-1:0]   dy;
    logic [ece_pkg::MagW-1:0]   h_val;
    logic                       pt_inside;
    logic [ece_pkg::RadW+2:0]   r_sum;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // Differences in 33 bits, then magnitudes; -(-2^32) is 2^32 unsigned in 33 bits
    assign dx = {r_px[31], r_px} - {r_cx[31], r_cx};
    assign dy = {r_py[31], r_py} - {r_cy[31], r_cy};

    // Strictly inside when the squared distance is below the squared radius
    assign pt_inside = (r_s < mul_prod);

    // d >= r is guaranteed once the point is not inside; d == 0 forces h == 0
    assign h_val = (iter_rsp.result - {2'b00, r_r}) >> 1;

    assign r_sum = {3'b000, r_r} + {1'b0, r_h};

    // Move a coordinate by the truncated step with the direction sign, saturating
    function automatic logic [31:0] move_coord(input logic [31:0] c, input logic neg,
                                               input logic [31:0] q);
        logic [33:0] sum;
        logic [31:0] res;
        sum = neg ? ({{2{c[31]}}, c} - {2'b00, q}) : ({{2{c[31]}}, c} + {2'b00, q});
        if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
            res = sum[31:0];
        end else if (sum[33]) begin
            res = 32'h8000_0000;
        end else begin
            res = 32'h7FFF_FFFF;
        end
        return res;
    endfunction

    ece_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    ece_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iter_req),
        .o_rsp   (iter_rsp)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ece_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ece_pkg::ST_DIFF;
                end
            end
            ece_pkg::ST_DIFF: n_state = ece_pkg::ST_MXX;
            ece_pkg::ST_MXX:  n_state = ece_pkg::ST_MYY;
            ece_pkg::ST_MYY:  n_state = ece_pkg::ST_MRR;
            ece_pkg::ST_MRR:  n_state = ece_pkg::ST_CMP;
            ece_pkg::ST_CMP:  n_state = pt_inside ? ece_pkg::ST_OUT : ece_pkg::ST_SQRT;
            ece_pkg::ST_SQRT: begin
                if (iter_rsp.done) begin
                    n_state = (h_val == '0) ? ece_pkg::ST_OUT : ece_pkg::ST_MHX;
                end
            end
            ece_pkg::ST_MHX:  n_state = ece_pkg::ST_DXS;
            ece_pkg::ST_DXS:  n_state = ece_pkg::ST_DXW;
            ece_pkg::ST_DXW: begin
                if (iter_rsp.done) begin
                    n_state = ece_pkg::ST_DYS;
                end
            end
            ece_pkg::ST_DYS:  n_state = ece_pkg::ST_DYW;
            ece_pkg::ST_DYW: begin
                if (iter_rsp.done) begin
                    n_state = ece_pkg::ST_UPD;
                end
            end
            ece_pkg::ST_UPD:  n_state = ece_pkg::ST_OUT;
            ece_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = ece_pkg::ST_IDLE;
                end
            end
            default:          n_state = ece_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, multiplier operands, unit requests
    always_comb begin
        s_axis_tready      = 1'b0;
        m_axis_tvalid      = 1'b0;
        mul_en             = 1'b0;
        mul_a              = r_ax;
        mul_b              = r_ax;
        iter_req.start     = 1'b0;
        iter_req.sqrt_mode = 1'b0;
        iter_req.operand   = mul_prod;
        iter_req.divisor   = r_d;
        unique case (r_state)
            ece_pkg::ST_IDLE: s_axis_tready = 1'b1;
            ece_pkg::ST_MXX: begin
                mul_en = 1'b1;
            end
            ece_pkg::ST_MYY: begin
                mul_en = 1'b1;
                mul_a  = r_ay;
                mul_b  = r_ay;
            end
            ece_pkg::ST_MRR: begin
                mul_en = 1'b1;
                mul_a  = {2'b00, r_r};
                mul_b  = {2'b00, r_r};
            end
            ece_pkg::ST_CMP: begin
                // squared distance into the unit while the radius square is compared
                iter_req.start     = !pt_inside;
                iter_req.sqrt_mode = 1'b1;
                iter_req.operand   = r_s;
            end
            ece_pkg::ST_MHX: begin
                mul_en = 1'b1;
                mul_b  = r_h;
            end
            ece_pkg::ST_DXS: begin
                iter_req.start = 1'b1;
                mul_en         = 1'b1;
                mul_a          = r_ay;
                mul_b          = r_h;
            end
            ece_pkg::ST_DYS: iter_req.start = 1'b1;
            ece_pkg::ST_OUT: m_axis_tvalid  = 1'b1;
            default: begin
            end
        endcase
    end

    // Control and circle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ece_pkg::ST_IDLE;
            r_cfg_cx <= '0;
            r_cfg_cy <= '0;
            r_cfg_r  <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_r      <= '0;
            r_grew   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    ece_pkg::CfgCenterX: r_cfg_cx <= i_cfg_data;
                    ece_pkg::CfgCenterY: r_cfg_cy <= i_cfg_data;
                    ece_pkg::CfgRadius:  r_cfg_r  <= i_cfg_data[ece_pkg::RadW-1:0];
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
            if (in_xfer) begin
                r_grew <= 1'b0;
                if (s_axis_tuser) begin
                    r_cx <= r_cfg_cx;
                    r_cy <= r_cfg_cy;
                    r_r  <= r_cfg_r;
                end
            end
            if (r_state == ece_pkg::ST_UPD) begin
                r_cx   <= move_coord(r_cx, r_negx, r_qx);
                r_cy   <= move_coord(r_cy, r_negy, r_qy);
                r_r    <= (r_sum[ece_pkg::RadW+2:ece_pkg::RadW] != 3'b000) ?
                          {ece_pkg::RadW{1'b1}} : r_sum[ece_pkg::RadW-1:0];
                r_grew <= 1'b1;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_px <= s_axis_tdata[31:0];
            r_py <= s_axis_tdata[63:32];
        end
        unique case (r_state)
            ece_pkg::ST_DIFF: begin
                r_negx <= dx[ece_pkg::MagW-1];
                r_negy <= dy[ece_pkg::MagW-1];
                r_ax   <= dx[ece_pkg::MagW-1] ? (~dx + 1'b1) : dx;
                r_ay   <= dy[ece_pkg::MagW-1] ? (~dy + 1'b1) : dy;
            end
            ece_pkg::ST_MYY: r_s <= mul_prod;
            ece_pkg::ST_MRR: r_s <= r_s + mul_prod;
            ece_pkg::ST_SQRT: begin
                if (iter_rsp.done) begin
                    r_d <= iter_rsp.result;
                    r_h <= h_val;
                end
            end
            ece_pkg::ST_DXW: begin
                if (iter_rsp.done) begin
                    r_qx <= iter_rsp.result[31:0];
                end
            end
            ece_pkg::ST_DYW: begin
                if (iter_rsp.done) begin
                    r_qy <= iter_rsp.result[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tdata = {1'b0, r_r, r_cy, r_cx};
    assign m_axis_tuser = r_grew;

endmodule
